// File: design/decimal_ascii_formatter_core_macros.svh
// Assertion macros shared by the checker of the decimal formatter core.
// Each macro expands to one labeled concurrent assertion on the rising clock.
`ifndef DECIMAL_ASCII_FORMATTER_CORE_MACROS_SVH
`define DECIMAL_ASCII_FORMATTER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define DAF_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("daf assertion failed");

// next-cycle implication, disabled while reset is high
`define DAF_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("daf assertion failed");

`endif

// File: design/daf_pkg.sv
// Shared types and constants of the decimal ASCII formatter core.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package daf_pkg;

   localparam int DataWidth       = 32;
   localparam int DigitCount      = 10;
   localparam int BcdWidth        = 4 * DigitCount;
   localparam int BitCountWidth   = $clog2(DataWidth);
   localparam int DigitCountWidth = $clog2(DigitCount + 1);
   localparam int CharWidth       = 6;

   localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture a new value, clear the BCD register
      logic step;   // one double-dabble step
      logic drop;   // discard the top digit
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bit_last;  // current step consumes the final binary bit
      logic top_zero;  // most significant remaining digit is zero
      logic one_left;  // only one digit remains
   } status_type;

endpackage

`default_nettype wire

// File: design/daf_datapath.sv
// Datapath of the decimal formatter: binary shift register, BCD register
// with add-3 correction, bit and digit counters. Depends on daf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module daf_datapath (
   input  wire logic                                 clock,
   input  wire daf_pkg::cmd_type                     cmd,
   input  wire logic [daf_pkg::DataWidth-1:0]        req_value,
   output daf_pkg::status_type                       status,
   output logic      [daf_pkg::CharWidth-1:0]        rsp_digit_char,
   output logic                                      rsp_last
);
   import daf_pkg::*;

   logic [DataWidth-1:0]       bin_ff,    bin_in;
   logic [BcdWidth-1:0]        bcd_ff,    bcd_in;
   logic [BitCountWidth-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DigitCountWidth-1:0] digits_ff, digits_in;
   logic [BcdWidth-1:0]        bcd_adj;
   logic [3:0]                 top_digit;

   // add 3 to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DigitCount; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      digits_in  = digits_ff;
      priority if (cmd.load) begin
         bin_in     = req_value;
         bcd_in     = '0;
         bit_cnt_in = '0;
         digits_in  = DigitCountWidth'(DigitCount);
      end else if (cmd.step) begin
         bcd_in     = {bcd_adj[BcdWidth-2:0], bin_ff[DataWidth-1]};
         bin_in     = {bin_ff[DataWidth-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 1'b1;
      end else if (cmd.drop) begin
         bcd_in    = {bcd_ff[BcdWidth-5:0], 4'd0};
         digits_in = digits_ff - 1'b1;
      end else begin
         // hold
         bin_in = bin_ff;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      digits_ff  <= digits_in;
   end

   assign top_digit       = bcd_ff[BcdWidth-1 -: 4];
   assign status.bit_last = (bit_cnt_ff == BitCountWidth'(DataWidth - 1));
   assign status.top_zero = (top_digit == 4'd0);
   assign status.one_left = (digits_ff == DigitCountWidth'(1));
   assign rsp_digit_char  = AsciiZero + {2'b00, top_digit};
   assign rsp_last        = status.one_left;

endmodule

`default_nettype wire

// File: design/daf_controller.sv
// Controller of the decimal formatter: sequences load, conversion,
// leading-zero skip and digit emission. Depends on daf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module daf_controller (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire daf_pkg::status_type status,
   output daf_pkg::cmd_type   cmd
);
   import daf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.step = 1'b1;
            if (status.bit_last) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (status.top_zero && !status.one_left) begin
               cmd.drop = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.drop = 1'b1;
               if (status.one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: design/decimal_ascii_formatter_core.sv
// Top level of the decimal ASCII formatter: controller plus datapath.
// Depends on daf_pkg, daf_controller and daf_datapath.
//
//   channel | ports                            | direction
//   req     | req_valid, req_ready, req_value  | in
//   rsp     | rsp_valid, rsp_ready, rsp_digit_char, rsp_last | out
//
// A value is loaded, converted by bit-serial double dabble with one step per
// input bit, stripped of its leading zeros, then emitted one digit at a time.
// Dropped zeros and digits always sum to ten; req_ready is high only when idle.
// Reset is synchronous and returns the controller to idle.
// A low rsp_ready holds the current digit and stalls the block.
`timescale 1ns / 1ps
`default_nettype none

module decimal_ascii_formatter_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [daf_pkg::DataWidth-1:0]  req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [daf_pkg::CharWidth-1:0]  rsp_digit_char,
   output logic                                rsp_last
);
   import daf_pkg::*;

   cmd_type    cmd;
   status_type status;

   daf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   daf_datapath u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .req_value      (req_value),
      .status         (status),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// File: design/daf_checker.sv
// Port-level checker for the decimal ASCII formatter core and its bind.
// Depends on decimal_ascii_formatter_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_ascii_formatter_core_macros.svh"

module daf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [31:0] req_value,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [5:0] rsp_digit_char,
   input wire logic       rsp_last
);

   logic req_xfer;
   logic last_xfer;

   assign req_xfer  = req_valid && req_ready && (req_value == req_value);
   assign last_xfer = rsp_valid && rsp_ready && rsp_last;

   // a stalled digit holds
   `DAF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last))

   `DAF_ASSERT_SAME(a_digit_range, clock, reset, rsp_valid, rsp_digit_char >= 6'd48 && rsp_digit_char <= 6'd57)

   `DAF_ASSERT_SAME(a_one_at_a_time, clock, reset, req_ready, !rsp_valid)

   `DAF_ASSERT_NEXT(a_busy_after_load, clock, reset, req_xfer, !req_ready && !rsp_valid)

   `DAF_ASSERT_NEXT(a_idle_after_last, clock, reset, last_xfer, req_ready && !rsp_valid)

endmodule

bind decimal_ascii_formatter_core daf_checker u_daf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_value      (req_value),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last       (rsp_last)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking bench for decimal_ascii_formatter_core: predicts the decimal digit
// stream of every accepted value and checks each digit transfer in order.
// Depends on daf_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module testbench;

   import daf_pkg::*;

   localparam int unsigned Radix      = 10;
   localparam int          CycleLimit = 1_000_000;
   localparam int          SettleWait = 60;
   localparam int          RandomRuns = 446;

   typedef struct {
      logic [CharWidth-1:0] digit_char;
      logic                 last;
   } digit_result_type;

   class digit_scoreboard;
      digit_result_type expected_digits[$];
      int               fail_count;

      function new();
         fail_count = 0;
      endfunction

      // expand one accepted value into its digits, most significant first
      function void note_value(logic [DataWidth-1:0] value);
         digit_result_type digits[$];
         digit_result_type one_digit;
         logic [DataWidth-1:0] rest;
         rest = value;
         do begin
            one_digit.digit_char = AsciiZero + CharWidth'(rest % Radix);
            one_digit.last       = 1'b0;
            digits.push_front(one_digit);
            rest = rest / Radix;
         end while (rest != 0);
         digits[digits.size() - 1].last = 1'b1;
         foreach (digits[i]) expected_digits.push_back(digits[i]);
      endfunction

      function void check_digit(logic [CharWidth-1:0] digit_char, logic last);
         digit_result_type want;
         if (expected_digits.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected digit transfer: char %0d last %0b", digit_char, last);
            return;
         end
         want = expected_digits.pop_front();
         if (digit_char !== want.digit_char || last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
               $display("digit mismatch: expected char %0d last %0b, got char %0d last %0b",
                        want.digit_char, want.last, digit_char, last);
         end
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [DataWidth-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   logic [CharWidth-1:0] rsp_digit_char;
   logic                 rsp_last;

   digit_scoreboard book = new();
   bit              idling_on = 1'b1;
   int              stall_left = 0;
   int              cycle_count = 0;

   logic [DataWidth-1:0] corner_values [24] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd999, 32'd1000,
      32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
      32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000, 32'd999999999,
      32'd1000000000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555
   };

   decimal_ascii_formatter_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("decimal_ascii_formatter_core verification failed");
         $finish;
      end
   end

   // receiver: check digit transfers, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_digit(rsp_digit_char, rsp_last);
      if (stall_left > 0)
         stall_left--;
      else if (idling_on && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 17);
      rsp_ready <= (stall_left == 0);
   end

   function automatic logic [DataWidth-1:0] pick_value();
      longint unsigned pow, lo, hi;
      int unsigned     digit_total, bit_pos;
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4, 5, 6: begin
            // uniform within a random digit count
            digit_total = $urandom_range(1, 10);
            pow = 1;
            repeat (digit_total - 1) pow = pow * Radix;
            lo = (digit_total == 1) ? 0 : pow;
            hi = (digit_total == 10) ? 64'hFFFF_FFFF : pow * Radix - 1;
            return DataWidth'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
         end
         7: begin
            pow = 1;
            repeat ($urandom_range(1, 9)) pow = pow * Radix;
            return DataWidth'(pow + $urandom_range(0, 2) - 1);
         end
         8: begin
            bit_pos = $urandom_range(0, DataWidth - 1);
            if ($urandom_range(0, 1) == 0)
               return DataWidth'(1) << bit_pos;
            return ~(DataWidth'(1) << bit_pos);
         end
         default: return $urandom_range(0, 20);
      endcase
   endfunction

   // call at a rising edge; returns at the edge of the transfer
   task automatic send_value(input logic [DataWidth-1:0] value);
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_value(value);
   endtask

   task automatic hold_sender(input int cycles);
      req_valid <= 1'b0;
      req_value <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (idling_on && $urandom_range(0, 3) == 0)
         hold_sender($urandom_range(1, 17));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_values[i]) begin
         send_value(corner_values[i]);
         maybe_gap();
      end

      for (int i = 0; i < RandomRuns; i++) begin
         if (i == RandomRuns / 3) begin
            // drain the core before sending on
            req_valid <= 1'b0;
            while (book.pending() != 0) @(posedge clock);
         end
         if (i == (RandomRuns * 2) / 3)
            idling_on = 1'b0;
         send_value(pick_value());
         maybe_gap();
      end
      req_valid <= 1'b0;

      while (book.pending() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);

      if (book.fail_count == 0 && book.pending() == 0)
         $display("decimal_ascii_formatter_core verification clean");
      else
         $display("decimal_ascii_formatter_core verification failed");
      $finish;
   end

endmodule
